/* rtl/ssfc_pkg.sv */
// Shared types, constants and lookup functions for the seven-segment frame composer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package ssfc_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam logic [3:0]  LAST_IDX  = 4'(FRAME_LEN - 1);

  localparam logic [7:0] CMD_DATA    = 8'h44;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] SEG_COLON   = 8'h80;
  localparam logic [7:0] SEG_UNKNOWN = 8'h40;
  localparam logic [7:0] CTRL_LVL0   = 8'h88;
  localparam logic [7:0] CTRL_BASE   = 8'h87;
  localparam logic [7:0] CTRL_OFF    = 8'h00;

  localparam logic [3:0]  LEVEL_MAX  = 4'd8;
  localparam logic [6:0]  TWO_DIG_MAX  = 7'd99;
  localparam logic [15:0] FOUR_DIG_MAX = 16'd9999;

  typedef enum logic [2:0] {
    REQ_TIME   = 3'd0,
    REQ_NUMBER = 3'd1,
    REQ_TEXT   = 3'd2,
    REQ_BLANK  = 3'd3,
    REQ_BRIGHT = 3'd4
  } req_type_t;

  typedef enum logic [0:0] {
    REG_BRIGHTNESS = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } digit_split_t;

  // One complete display frame, ready to be sent out word by word.
  typedef struct packed {
    logic            single;
    logic [3:0][7:0] seg;
    logic [7:0]      ctrl;
  } frame_t;

  // Splits off the leading decimal digit of a value below ten units.
  // The compares against each multiple are independent; the last hit wins.
  function automatic digit_split_t split_digit(input logic [13:0] value,
                                               input logic [13:0] unit);
    digit_split_t res;
    res.digit = 4'd0;
    res.rem   = value;
    for (int k = 1; k < 10; k++) begin
      if (value >= 14'(unit * k)) begin
        res.digit = 4'(k);
        res.rem   = value - 14'(unit * k);
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] glyph_seg(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      "0": s = 8'h3F;
      "1": s = 8'h06;
      "2": s = 8'h5B;
      "3": s = 8'h4F;
      "4": s = 8'h66;
      "5": s = 8'h6D;
      "6": s = 8'h7D;
      "7": s = 8'h07;
      "8": s = 8'h7F;
      "9": s = 8'h6F;
      "A", "a": s = 8'h77;
      "B", "b": s = 8'h7C;
      "C": s = 8'h39;
      "c": s = 8'h58;
      "D", "d": s = 8'h5E;
      "E", "e": s = 8'h79;
      "F", "f": s = 8'h71;
      "G", "g": s = 8'h2F;
      "H": s = 8'h76;
      "h": s = 8'h74;
      "I", "i": s = 8'h10;
      "J", "j": s = 8'h1E;
      "K", "k": s = 8'h70;
      "L", "l": s = 8'h38;
      "N", "n": s = 8'h54;
      "O", "o": s = 8'h5C;
      "P", "p": s = 8'h73;
      "Q", "q": s = 8'h67;
      "R", "r": s = 8'h50;
      "T", "t": s = 8'h78;
      "U": s = 8'h3E;
      "u": s = 8'h1C;
      ":": s = 8'h80;
      "-": s = 8'h40;
      "_": s = 8'h08;
      default: s = SEG_UNKNOWN;
    endcase
    return s;
  endfunction

endpackage

/* rtl/ssfc_serializer.sv */
// Frame serializer: holds one frame and sends it out one word per cycle with framing marks.
// Depends on ssfc_pkg for frame_t and the command constants.
`timescale 1ns / 1ps

module ssfc_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ssfc_pkg::frame_t frame_in,
  output logic            free,
  output logic            strobe,
  output logic [7:0]      tx_byte,
  output logic            start_before,
  output logic            stop_after,
  output logic            last_byte
);
  import ssfc_pkg::*;

  logic       active;
  logic [3:0] cnt;
  frame_t     frame;
  logic       last;
  logic [1:0] seg_idx;

  assign last = active && (frame.single || cnt == LAST_IDX);
  // A new frame may load in the cycle that the current one sends its final word.
  assign free = !active || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= 4'd0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= 4'd0;
    end else if (active) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_in;
    end
  end

  // Odd words below nine carry digit addresses, even words from two to eight carry segments.
  assign seg_idx = cnt[0] ? cnt[2:1] : 2'(cnt[3:1] - 3'd1);

  always_comb begin
    strobe       = active;
    tx_byte      = 8'h00;
    start_before = 1'b0;
    stop_after   = 1'b0;
    last_byte    = 1'b0;
    if (frame.single || cnt == LAST_IDX) begin
      tx_byte      = frame.ctrl;
      start_before = 1'b1;
      stop_after   = 1'b1;
      last_byte    = 1'b1;
    end else if (cnt == 4'd0) begin
      tx_byte      = CMD_DATA;
      start_before = 1'b1;
      stop_after   = 1'b1;
    end else if (cnt[0]) begin
      tx_byte      = CMD_ADDR + {6'd0, seg_idx};
      start_before = 1'b1;
    end else begin
      tx_byte      = frame.seg[seg_idx];
      stop_after   = 1'b1;
    end
  end

endmodule

/* rtl/seven_segment_frame_composer.sv */
// Top level of the seven-segment frame composer: request pipeline and APB register.
// Depends on ssfc_pkg and instantiates ssfc_serializer.
`timescale 1ns / 1ps

//  channel   | handshake                          | payload
//  ----------+------------------------------------+-------------------------------------
//  request   | start, busy (taken: start & !busy) | req_type, hours, minutes, number,
//            |                                    | char_first .. char_fifth
//  result    | strobe (one cycle, no stall)       | tx_byte, start_before, stop_after,
//            |                                    | last_byte
//  register  | APB, pready tied high              | brightness_level at byte address 0
//
// A request runs through four register stages (capture, thousands and tens split,
// hundreds split with glyph lookup, final digits and frame build); its first word is
// on the result ports once the serializer has loaded the frame from the last stage.
// The serializer then sends one word a cycle: ten words per display frame, one per
// brightness request, none for unknown types. Requests keep entering while a frame is
// being sent; busy rises only when every stage is full. Reset clears all valid bits and
// sets brightness level zero.

module seven_segment_frame_composer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [6:0]  hours,
  input  logic [6:0]  minutes,
  input  logic [15:0] number,
  input  logic [7:0]  char_first,
  input  logic [7:0]  char_second,
  input  logic [7:0]  char_third,
  input  logic [7:0]  char_fourth,
  input  logic [7:0]  char_fifth,
  output logic        strobe,
  output logic [7:0]  tx_byte,
  output logic        start_before,
  output logic        stop_after,
  output logic        last_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssfc_pkg::*;

  // Configuration register.
  logic [3:0] brightness_level;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_BRIGHTNESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level <= 4'd0;
    end else if (psel && penable && pwrite && pready && reg_sel &&
                 pwdata[3:0] <= LEVEL_MAX) begin
      brightness_level <= pwdata[3:0];
    end
  end

  assign prdata = reg_sel ? {28'd0, brightness_level} : 32'd0;

  // Pipeline flow control.
  logic ser_free, ready_a, ready_b, ready_c, ready_d, d_take;
  logic a_valid, b_valid, c_valid, d_valid;

  assign ready_d = !d_valid || ser_free;
  assign ready_c = !c_valid || ready_d;
  assign ready_b = !b_valid || ready_c;
  assign ready_a = !a_valid || ready_b;
  assign busy    = !ready_a;
  assign d_take  = d_valid && ser_free;

  // Stage A: capture.
  logic [2:0]  a_type;
  logic [6:0]  a_hours, a_minutes;
  logic [15:0] a_number;
  logic [7:0]  a_c1, a_c2, a_c3, a_c4, a_c5;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_type    <= req_type;
      a_hours   <= hours;
      a_minutes <= minutes;
      a_number  <= number;
      a_c1      <= char_first;
      a_c2      <= char_second;
      a_c3      <= char_third;
      a_c4      <= char_fourth;
      a_c5      <= char_fifth;
    end
  end

  // Stage B: saturate, split thousands and the tens of hours and minutes.
  logic [6:0]   hs, ms;
  logic [13:0]  ns;
  digit_split_t sp_th, sp_h, sp_m;

  always_comb begin
    hs    = (a_hours > TWO_DIG_MAX) ? TWO_DIG_MAX : a_hours;
    ms    = (a_minutes > TWO_DIG_MAX) ? TWO_DIG_MAX : a_minutes;
    ns    = (a_number > FOUR_DIG_MAX) ? 14'(FOUR_DIG_MAX) : a_number[13:0];
    sp_th = split_digit(ns, 14'd1000);
    sp_h  = split_digit({7'd0, hs}, 14'd10);
    sp_m  = split_digit({7'd0, ms}, 14'd10);
  end

  logic [2:0] b_type;
  logic [3:0] b_th, b_h_t, b_h_o, b_m_t, b_m_o;
  logic [9:0] b_rem;
  logic [7:0] b_c1, b_c2, b_c3, b_c4, b_c5;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      b_type <= a_type;
      b_th   <= sp_th.digit;
      b_rem  <= sp_th.rem[9:0];
      b_h_t  <= sp_h.digit;
      b_h_o  <= sp_h.rem[3:0];
      b_m_t  <= sp_m.digit;
      b_m_o  <= sp_m.rem[3:0];
      b_c1   <= a_c1;
      b_c2   <= a_c2;
      b_c3   <= a_c3;
      b_c4   <= a_c4;
      b_c5   <= a_c5;
    end
  end

  // Stage C: hundreds split and text glyphs.
  digit_split_t    sp_hu;
  logic [3:0][7:0] text_seg;

  always_comb begin
    sp_hu = split_digit({4'd0, b_rem}, 14'd100);
    text_seg[0] = glyph_seg(b_c1);
    if (b_c5 == 8'd0) begin
      text_seg[1] = glyph_seg(b_c2);
      text_seg[2] = glyph_seg(b_c3);
      text_seg[3] = glyph_seg(b_c4);
    end else begin
      // Five characters: the third is dropped and the colon is lit.
      text_seg[1] = glyph_seg(b_c2) | SEG_COLON;
      text_seg[2] = glyph_seg(b_c4);
      text_seg[3] = glyph_seg(b_c5);
    end
  end

  logic [2:0]      c_type;
  logic [3:0]      c_th, c_hu, c_h_t, c_h_o, c_m_t, c_m_o;
  logic [6:0]      c_rem;
  logic [3:0][7:0] c_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (ready_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c) begin
      c_type <= b_type;
      c_th   <= b_th;
      c_hu   <= sp_hu.digit;
      c_rem  <= sp_hu.rem[6:0];
      c_h_t  <= b_h_t;
      c_h_o  <= b_h_o;
      c_m_t  <= b_m_t;
      c_m_o  <= b_m_o;
      c_text <= text_seg;
    end
  end

  // Stage D: last digits and frame build.
  digit_split_t sp_te;
  frame_t       frame_next;
  logic         frame_ok;
  logic [7:0]   ctrl_on;

  always_comb begin
    sp_te   = split_digit({7'd0, c_rem}, 14'd10);
    ctrl_on = (brightness_level == 4'd0) ? CTRL_LVL0 : CTRL_BASE + {4'd0, brightness_level};
    frame_next.single = 1'b0;
    frame_next.ctrl   = ctrl_on;
    frame_next.seg    = '0;
    frame_ok          = 1'b1;
    case (c_type)
      REQ_TIME: begin
        frame_next.seg[0] = digit_seg(c_h_t);
        frame_next.seg[1] = digit_seg(c_h_o) | SEG_COLON;
        frame_next.seg[2] = digit_seg(c_m_t);
        frame_next.seg[3] = digit_seg(c_m_o);
      end
      REQ_NUMBER: begin
        frame_next.seg[0] = digit_seg(c_th);
        frame_next.seg[1] = digit_seg(c_hu);
        frame_next.seg[2] = digit_seg(sp_te.digit);
        frame_next.seg[3] = digit_seg(sp_te.rem[3:0]);
      end
      REQ_TEXT: begin
        frame_next.seg = c_text;
      end
      REQ_BLANK: begin
        frame_next.ctrl = CTRL_OFF;
      end
      REQ_BRIGHT: begin
        frame_next.single = 1'b1;
      end
      default: begin
        // Unknown request types send nothing and vanish here.
        frame_ok = 1'b0;
      end
    endcase
  end

  frame_t d_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (ready_d) begin
      d_valid <= c_valid && frame_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d) begin
      d_frame <= frame_next;
    end
  end

  ssfc_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .load         (d_take),
    .frame_in     (d_frame),
    .free         (ser_free),
    .strobe       (strobe),
    .tx_byte      (tx_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last_byte    (last_byte)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for seven_segment_frame_composer.
// Drives display requests and APB brightness writes, and checks every output word against
// a local frame predictor. Depends on rtl/ssfc_pkg.sv and rtl/seven_segment_frame_composer.sv.
`timescale 1ns / 1ps

module testbench;
  import ssfc_pkg::*;

  typedef enum logic [1:0] {
    FRAME_NONE,
    FRAME_SINGLE,
    FRAME_FULL
  } frame_shape_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [15:0] number;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [7:0]  c4;
    logic [7:0]  c5;
  } request_t;

  typedef struct packed {
    frame_shape_t     shape;
    logic [0:3][7:0]  seg;
    logic [7:0]       ctrl;
  } expected_frame_t;

  typedef struct packed {
    request_t        req;
    logic            typed;
    expected_frame_t want;
  } directed_row_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       st;
    logic       sp;
    logic       last;
  } word_t;

  localparam logic [2:0] BRIGHT_ADDR   = 3'(4 * REG_BRIGHTNESS);
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 32;
  localparam int         DRAIN_CYCLES  = 12;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [6:0]  hours;
  logic [6:0]  minutes;
  logic [15:0] number;
  logic [7:0]  char_first;
  logic [7:0]  char_second;
  logic [7:0]  char_third;
  logic [7:0]  char_fourth;
  logic [7:0]  char_fifth;
  logic        strobe;
  logic [7:0]  tx_byte;
  logic        start_before;
  logic        stop_after;
  logic        last_byte;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  word_t         pending_words[$];
  directed_row_t directed_rows[$];
  logic [3:0]    brightness_mirror;
  logic [8:0]    levels_used;
  int            requests_taken;
  int            words_checked;
  int            error_count;
  string         glyph_alphabet = "0123456789AaBbCcDdEeFfGgHhIiJjKkLlNnOoPpQqRrTtUu:-_";

  seven_segment_frame_composer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .hours(hours), .minutes(minutes), .number(number),
    .char_first(char_first), .char_second(char_second), .char_third(char_third),
    .char_fourth(char_fourth), .char_fifth(char_fifth),
    .strobe(strobe), .tx_byte(tx_byte), .start_before(start_before),
    .stop_after(stop_after), .last_byte(last_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] digit_pattern(input int d);
    logic [7:0] p;
    case (d)
      0: p = 8'h3F;
      1: p = 8'h06;
      2: p = 8'h5B;
      3: p = 8'h4F;
      4: p = 8'h66;
      5: p = 8'h6D;
      6: p = 8'h7D;
      7: p = 8'h07;
      8: p = 8'h7F;
      default: p = 8'h6F;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] char_pattern(input logic [7:0] c);
    logic [7:0] p;
    if (c >= "0" && c <= "9") begin
      p = digit_pattern(int'(c - "0"));
    end else begin
      case (c)
        "A", "a": p = 8'h77;
        "B", "b": p = 8'h7C;
        "C":      p = 8'h39;
        "c":      p = 8'h58;
        "D", "d": p = 8'h5E;
        "E", "e": p = 8'h79;
        "F", "f": p = 8'h71;
        "G", "g": p = 8'h2F;
        "H":      p = 8'h76;
        "h":      p = 8'h74;
        "I", "i": p = 8'h10;
        "J", "j": p = 8'h1E;
        "K", "k": p = 8'h70;
        "L", "l": p = 8'h38;
        "N", "n": p = 8'h54;
        "O", "o": p = 8'h5C;
        "P", "p": p = 8'h73;
        "Q", "q": p = 8'h67;
        "R", "r": p = 8'h50;
        "T", "t": p = 8'h78;
        "U":      p = 8'h3E;
        "u":      p = 8'h1C;
        ":":      p = SEG_COLON;
        "-":      p = 8'h40;
        "_":      p = 8'h08;
        default:  p = SEG_UNKNOWN;
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] control_for(input logic [3:0] level);
    return (level == 4'd0) ? CTRL_LVL0 : 8'(CTRL_BASE + level);
  endfunction

  // Works out the frame that a request should produce at the given brightness level.
  function automatic expected_frame_t compose_frame(input request_t r, input logic [3:0] level);
    expected_frame_t f;
    int h;
    int m;
    int n;
    f.shape = FRAME_FULL;
    f.seg   = '0;
    f.ctrl  = control_for(level);
    case (r.kind)
      REQ_TIME: begin
        h = (r.hours > 7'd99) ? 99 : int'(r.hours);
        m = (r.minutes > 7'd99) ? 99 : int'(r.minutes);
        f.seg[0] = digit_pattern(h / 10);
        f.seg[1] = digit_pattern(h % 10) | SEG_COLON;
        f.seg[2] = digit_pattern(m / 10);
        f.seg[3] = digit_pattern(m % 10);
      end
      REQ_NUMBER: begin
        n = (r.number > 16'd9999) ? 9999 : int'(r.number);
        f.seg[0] = digit_pattern(n / 1000);
        f.seg[1] = digit_pattern((n / 100) % 10);
        f.seg[2] = digit_pattern((n / 10) % 10);
        f.seg[3] = digit_pattern(n % 10);
      end
      REQ_TEXT: begin
        f.seg[0] = char_pattern(r.c1);
        if (r.c5 == 8'd0) begin
          f.seg[1] = char_pattern(r.c2);
          f.seg[2] = char_pattern(r.c3);
          f.seg[3] = char_pattern(r.c4);
        end else begin
          // Five characters: the third one is dropped and the colon is lit.
          f.seg[1] = char_pattern(r.c2) | SEG_COLON;
          f.seg[2] = char_pattern(r.c4);
          f.seg[3] = char_pattern(r.c5);
        end
      end
      REQ_BLANK: f.ctrl = CTRL_OFF;
      REQ_BRIGHT: f.shape = FRAME_SINGLE;
      default: f.shape = FRAME_NONE;
    endcase
    return f;
  endfunction

  task automatic queue_words(input expected_frame_t f);
    if (f.shape == FRAME_SINGLE) begin
      pending_words.push_back({f.ctrl, 1'b1, 1'b1, 1'b1});
    end else if (f.shape == FRAME_FULL) begin
      pending_words.push_back({CMD_DATA, 1'b1, 1'b1, 1'b0});
      for (int d = 0; d < 4; d++) begin
        pending_words.push_back({8'(CMD_ADDR + d), 1'b1, 1'b0, 1'b0});
        pending_words.push_back({f.seg[d], 1'b0, 1'b1, 1'b0});
      end
      pending_words.push_back({f.ctrl, 1'b1, 1'b1, 1'b1});
    end
  endtask

  function automatic request_t mk_time(input int h, input int m);
    request_t r;
    r = '0;
    r.kind    = REQ_TIME;
    r.hours   = 7'(h);
    r.minutes = 7'(m);
    return r;
  endfunction

  function automatic request_t mk_number(input int n);
    request_t r;
    r = '0;
    r.kind   = REQ_NUMBER;
    r.number = 16'(n);
    return r;
  endfunction

  function automatic request_t mk_text(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d,
                                       input logic [7:0] e);
    request_t r;
    r = '0;
    r.kind = REQ_TEXT;
    r.c1 = a;
    r.c2 = b;
    r.c3 = c;
    r.c4 = d;
    r.c5 = e;
    return r;
  endfunction

  function automatic request_t mk_other(input logic [2:0] kind);
    request_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic directed_row_t row(input request_t r, input logic typed,
                                        input frame_shape_t shape, input logic [31:0] segs,
                                        input logic [7:0] ctrl);
    directed_row_t t;
    t.req        = r;
    t.typed      = typed;
    t.want.shape = shape;
    t.want.seg   = segs;
    t.want.ctrl  = ctrl;
    return t;
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 9) < 7) begin
      return glyph_alphabet[$urandom_range(0, glyph_alphabet.len() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] rand_two_digit();
    if ($urandom_range(0, 99) < 85) begin
      return 7'($urandom_range(0, 99));
    end
    return 7'($urandom_range(100, 127));
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int pick;
    pick      = $urandom_range(0, 99);
    r.hours   = rand_two_digit();
    r.minutes = rand_two_digit();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.number = 16'($urandom);
      9:          r.number = 16'($urandom_range(9990, 10010));
      default:    r.number = 16'($urandom_range(0, 9999));
    endcase
    r.c1 = rand_char();
    r.c2 = rand_char();
    r.c3 = rand_char();
    r.c4 = rand_char();
    r.c5 = ($urandom_range(0, 99) < 45) ? 8'd0 : rand_char();
    if (pick < 22) begin
      r.kind = REQ_TIME;
    end else if (pick < 44) begin
      r.kind = REQ_NUMBER;
    end else if (pick < 70) begin
      r.kind = REQ_TEXT;
    end else if (pick < 80) begin
      r.kind = REQ_BLANK;
    end else if (pick < 92) begin
      r.kind = REQ_BRIGHT;
    end else begin
      r.kind = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // Presents one request after the given number of idle cycles and waits until it is taken.
  task automatic submit(input request_t r, input expected_frame_t f, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type    <= r.kind;
    hours       <= r.hours;
    minutes     <= r.minutes;
    number      <= r.number;
    char_first  <= r.c1;
    char_second <= r.c2;
    char_third  <= r.c3;
    char_fourth <= r.c4;
    char_fifth  <= r.c5;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_words(f);
    requests_taken++;
    levels_used[brightness_mirror] = 1'b1;
  endtask

  // Brings the block to rest: no request offered and every expected word delivered.
  // Unknown request types leave no word behind, so a further wait after the queue empties lets them drain.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads the brightness register back and compares it with the local copy.
  task automatic check_brightness();
    logic [31:0] rd;
    apb_access(1'b0, BRIGHT_ADDR, 32'd0, rd);
    if (rd !== 32'(brightness_mirror)) begin
      $error("prdata: expected %h, got %h", 32'(brightness_mirror), rd);
      error_count++;
    end
  endtask

  task automatic write_brightness(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    apb_access(1'b1, addr, data, rd);
    // Out-of-range levels and writes to other addresses leave the register alone.
    if (addr == BRIGHT_ADDR && data[3:0] <= LEVEL_MAX) begin
      brightness_mirror = data[3:0];
    end
    check_brightness();
  endtask

  always @(posedge clk) begin
    word_t want;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: tx_byte %h", tx_byte);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (tx_byte !== want.tx) begin
          $error("tx_byte: expected %h, got %h", want.tx, tx_byte);
          error_count++;
        end
        if (start_before !== want.st) begin
          $error("start_before: expected %b, got %b", want.st, start_before);
          error_count++;
        end
        if (stop_after !== want.sp) begin
          $error("stop_after: expected %b, got %b", want.sp, stop_after);
          error_count++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %b, got %b", want.last, last_byte);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int gap;
    int burst_left;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = '0;
    hours       = '0;
    minutes     = '0;
    number      = '0;
    char_first  = '0;
    char_second = '0;
    char_third  = '0;
    char_fourth = '0;
    char_fifth  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    brightness_mirror = 4'd0;
    levels_used    = '0;
    requests_taken = 0;
    words_checked  = 0;
    error_count    = 0;

    directed_rows.push_back(row(mk_other(REQ_BRIGHT), 1'b1, FRAME_SINGLE, 32'h0, 8'h88));
    directed_rows.push_back(row(mk_time(0, 0), 1'b1, FRAME_FULL, 32'h3FBF3F3F, 8'h88));
    directed_rows.push_back(row(mk_time(127, 127), 1'b1, FRAME_FULL, 32'h6FEF6F6F, 8'h88));
    directed_rows.push_back(row(mk_time(12, 34), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_time(23, 59), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_time(100, 7), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_number(0), 1'b1, FRAME_FULL, 32'h3F3F3F3F, 8'h88));
    directed_rows.push_back(row(mk_number(65535), 1'b1, FRAME_FULL, 32'h6F6F6F6F, 8'h88));
    directed_rows.push_back(row(mk_number(9999), 1'b1, FRAME_FULL, 32'h6F6F6F6F, 8'h88));
    directed_rows.push_back(row(mk_number(10000), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_number(1234), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_number(5670), 1'b0, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_text("H", "E", "L", "P", 8'h00), 1'b0, FRAME_NONE,
                                32'h0, 8'h0));
    directed_rows.push_back(row(mk_text(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, FRAME_FULL,
                                32'h40404040, 8'h88));
    directed_rows.push_back(row(mk_text(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, FRAME_FULL,
                                32'h40C04040, 8'h88));
    directed_rows.push_back(row(mk_text(":", ":", ":", ":", ":"), 1'b1, FRAME_FULL,
                                32'h80808080, 8'h88));
    directed_rows.push_back(row(mk_text("1", "2", "x", "3", "4"), 1'b0, FRAME_NONE,
                                32'h0, 8'h0));
    directed_rows.push_back(row(mk_text("a", "b", "c", "d", 8'h00), 1'b0, FRAME_NONE,
                                32'h0, 8'h0));
    directed_rows.push_back(row(mk_text("-", "_", "U", "u", "Z"), 1'b0, FRAME_NONE,
                                32'h0, 8'h0));
    directed_rows.push_back(row(mk_text("O", "n", "i", "t", 8'h00), 1'b0, FRAME_NONE,
                                32'h0, 8'h0));
    directed_rows.push_back(row(mk_other(REQ_BLANK), 1'b1, FRAME_FULL, 32'h0, CTRL_OFF));
    directed_rows.push_back(row(mk_other(3'd5), 1'b1, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_other(3'd6), 1'b1, FRAME_NONE, 32'h0, 8'h0));
    directed_rows.push_back(row(mk_other(3'd7), 1'b1, FRAME_NONE, 32'h0, 8'h0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_brightness();

    foreach (directed_rows[i]) begin
      submit(directed_rows[i].req,
             directed_rows[i].typed ? directed_rows[i].want
                                    : compose_frame(directed_rows[i].req, brightness_mirror),
             $urandom_range(0, 2));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: write_brightness(BRIGHT_ADDR, 32'd8);
        1: write_brightness(BRIGHT_ADDR, 32'd1);
        2: write_brightness(BRIGHT_ADDR, 32'h0000_000F);
        3: write_brightness(ADDR_UNMAPPED, 32'd5);
        4: write_brightness(BRIGHT_ADDR, 32'd0);
        5: write_brightness(BRIGHT_ADDR, ($urandom & 32'hFFFF_FFF0) | 32'd3);
        default: begin
          cfg_addr = ($urandom_range(0, 4) == 0) ? ADDR_UNMAPPED : BRIGHT_ADDR;
          cfg_data = $urandom;
          write_brightness(cfg_addr, cfg_data);
        end
      endcase
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        request_t r;
        r = rand_request();
        // Two phases run back to back without pauses to keep the pipeline full.
        if (phase == 2 || phase == 5 || burst_left > 0) begin
          gap = 0;
        end else begin
          gap = $urandom_range(1, 25);
          burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
          burst_left--;
        end
        submit(r, compose_frame(r, brightness_mirror), gap);
      end
    end

    settle();
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      error_count++;
    end
    $display("Sent %0d requests over %0d register settings; checked %0d output words.",
             requests_taken, PHASES + 1, words_checked);
    $display("Brightness levels in use while requests were taken: %b", levels_used);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
